// ===== rtl/dns_response_address_parser_macros.svh =====
// Assertion macros shared by the DNS response address parser modules.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
// Every assertion is disabled while the active-low reset is asserted.
`ifndef DNS_RESPONSE_ADDRESS_PARSER_MACROS_SVH
`define DNS_RESPONSE_ADDRESS_PARSER_MACROS_SVH

// The condition must hold at every clock edge.
`define DRAP_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("drap assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define DRAP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drap assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DRAP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drap assertion failed");

`endif

// ===== rtl/drap_pkg.sv =====
// Package for the DNS response address parser: transfer payload types,
// parser phase encoding, status and record codes, and queue sizing.
// Depends on nothing; every RTL module imports it.
package drap_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } drap_item_t;

    typedef struct packed {
        logic        kind;
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [2:0]  status;
        logic [3:0]  response_code;
        logic [15:0] answer_total;
        logic        final_res;
    } drap_result_t;

    typedef struct packed {
        logic [1:0]   count;
        drap_result_t first;
        drap_result_t second;
    } drap_push_t;

    typedef enum logic [8:0] {
        PH_HEADER   = 9'b000000001,
        PH_QUESTION = 9'b000000010,
        PH_NAME     = 9'b000000100,
        PH_LABEL    = 9'b000001000,
        PH_POINTER  = 9'b000010000,
        PH_FIXED    = 9'b000100000,
        PH_RDATA    = 9'b001000000,
        PH_DONE     = 9'b010000000,
        PH_ERROR    = 9'b100000000
    } drap_phase_t;

    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;
    localparam logic FAMILY_IPV4  = 1'b0;
    localparam logic FAMILY_IPV6  = 1'b1;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd1;
    localparam logic [2:0] ST_RCODE_ERROR  = 3'd2;
    localparam logic [2:0] ST_QDCOUNT_BAD  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED    = 3'd4;

    localparam logic [15:0] RR_TYPE_A    = 16'd1;
    localparam logic [15:0] RR_TYPE_AAAA = 16'd28;
    localparam logic [15:0] QDCOUNT_ONE  = 16'd1;

    localparam int QR_BIT = 7;
    localparam logic [1:0] POINTER_TAG = 2'b11;

    localparam int SEC_W = 9;
    localparam logic [SEC_W-1:0] HDR_QR_BYTE      = 9'd2;
    localparam logic [SEC_W-1:0] HDR_FLAGS_BYTE   = 9'd3;
    localparam logic [SEC_W-1:0] HDR_QD_HI_BYTE   = 9'd4;
    localparam logic [SEC_W-1:0] HDR_QD_LO_BYTE   = 9'd5;
    localparam logic [SEC_W-1:0] HDR_AN_HI_BYTE   = 9'd6;
    localparam logic [SEC_W-1:0] HDR_AN_LO_BYTE   = 9'd7;
    localparam logic [SEC_W-1:0] HDR_LAST_BYTE    = 9'd11;
    localparam logic [SEC_W-1:0] FIX_TYPE_END     = 9'd2;
    localparam logic [SEC_W-1:0] FIX_RDLEN_FIRST  = 9'd8;
    localparam logic [SEC_W-1:0] FIX_LAST_BYTE    = 9'd9;

    localparam int ABC_W = 5;
    localparam logic [ABC_W-1:0] IPV4_BYTES     = 5'd4;
    localparam logic [ABC_W-1:0] IPV6_BYTES     = 5'd16;
    localparam logic [ABC_W-1:0] IPV6_HIGH_BYTES = 5'd8;

    localparam int QLEN_W = 9;
    localparam logic [QLEN_W-1:0] QLEN_RESET = 9'd5;

    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int ROOM_LIMIT  = FIFO_DEPTH - 2 * MAX_RESULTS;

endpackage

// ===== rtl/drap_result_fifo.sv =====
// Result queue of the DNS response address parser: takes up to two results
// per cycle and hands out one per transfer. Depends on drap_pkg and the
// assertion macro header.
`include "dns_response_address_parser_macros.svh"

module drap_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  drap_pkg::drap_push_t push,
    input  logic                 pop,
    output drap_pkg::drap_result_t head,
    output logic                 not_empty,
    output logic                 room
);
    import drap_pkg::*;

    drap_result_t mem [FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next   = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
    assign count_next    = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(ROOM_LIMIT));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DRAP_ASSERT_ALWAYS(a_fifo_bounded, clk, rst_n, count_reg <= CNT_W'(FIFO_DEPTH))
    `DRAP_ASSERT_ALWAYS(a_fifo_push_legal, clk, rst_n, push.count != 2'd3)
    `DRAP_ASSERT_NEXT(a_fifo_idle_holds, clk, rst_n, (push.count == 2'd0) && !pop, $stable(count_reg))

endmodule

// ===== rtl/drap_parser.sv =====
// Message parser of the DNS response address parser: holds the parse state
// and turns one registered message byte into at most two results per cycle.
// Depends on drap_pkg and the assertion macro header.
`include "dns_response_address_parser_macros.svh"

module drap_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  drap_pkg::drap_item_t     item,
    input  logic [drap_pkg::QLEN_W-1:0] question_length,
    output drap_pkg::drap_push_t     push
);
    import drap_pkg::*;

    drap_phase_t      phase_reg, phase_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [15:0]      answers_left_reg, answers_left_next;
    logic [15:0]      ancount_reg, ancount_next;
    logic [3:0]       rcode_reg, rcode_next;
    logic [2:0]       err_reg, err_next;
    logic [15:0]      rtype_reg, rtype_next;
    logic [15:0]      rdata_left_reg, rdata_left_next;
    logic [7:0]       label_reg, label_next;
    logic [63:0]      addr_lo_reg, addr_lo_next;
    logic [63:0]      addr_hi_reg, addr_hi_next;
    logic [ABC_W-1:0] abc_reg, abc_next;

    logic [7:0]   b;
    logic         eom;
    logic         hdr_fail;
    logic         addr_hit;
    logic         addr_family;
    logic [63:0]  res_hi;
    logic [63:0]  res_lo;
    logic [2:0]   st;
    drap_result_t addr_res;
    drap_result_t status_res;

    always_comb
    begin
        phase_next        = phase_reg;
        sec_next          = sec_reg;
        answers_left_next = answers_left_reg;
        ancount_next      = ancount_reg;
        rcode_next        = rcode_reg;
        err_next          = err_reg;
        rtype_next        = rtype_reg;
        rdata_left_next   = rdata_left_reg;
        label_next        = label_reg;
        addr_lo_next      = addr_lo_reg;
        addr_hi_next      = addr_hi_reg;
        abc_next          = abc_reg;
        b                 = item.data_byte;
        eom               = item.end_of_message;
        hdr_fail          = 1'b0;
        addr_hit          = 1'b0;
        addr_family       = FAMILY_IPV4;
        res_hi            = '0;
        res_lo            = '0;

        if (item_valid)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (sec_reg == HDR_QR_BYTE)
                    begin
                        if (!b[QR_BIT])
                        begin
                            err_next   = ST_NOT_RESPONSE;
                            phase_next = PH_ERROR;
                            hdr_fail   = 1'b1;
                        end
                    end
                    else if (sec_reg == HDR_FLAGS_BYTE)
                    begin
                        rcode_next = b[3:0];
                        if (b[3:0] != 4'd0)
                        begin
                            err_next   = ST_RCODE_ERROR;
                            phase_next = PH_ERROR;
                            hdr_fail   = 1'b1;
                        end
                    end
                    else if (sec_reg == HDR_QD_HI_BYTE)
                    begin
                        rtype_next = {8'd0, b};
                    end
                    else if (sec_reg == HDR_QD_LO_BYTE)
                    begin
                        rtype_next = {rtype_reg[7:0], b};
                        if ({rtype_reg[7:0], b} != QDCOUNT_ONE)
                        begin
                            err_next   = ST_QDCOUNT_BAD;
                            phase_next = PH_ERROR;
                            hdr_fail   = 1'b1;
                        end
                    end
                    else if (sec_reg == HDR_AN_HI_BYTE)
                    begin
                        ancount_next = {8'd0, b};
                    end
                    else if (sec_reg == HDR_AN_LO_BYTE)
                    begin
                        ancount_next      = {ancount_reg[7:0], b};
                        answers_left_next = {ancount_reg[7:0], b};
                    end
                    if (!hdr_fail)
                    begin
                        if (sec_reg >= HDR_LAST_BYTE)
                        begin
                            rtype_next = '0;
                            if (question_length == '0)
                            begin
                                phase_next = (answers_left_next == 16'd0) ? PH_DONE : PH_NAME;
                            end
                            else
                            begin
                                phase_next = PH_QUESTION;
                                sec_next   = question_length;
                            end
                        end
                        else
                        begin
                            sec_next = sec_reg + SEC_W'(1);
                        end
                    end
                end
                PH_QUESTION:
                begin
                    sec_next = sec_reg - SEC_W'(1);
                    if (sec_next == '0)
                    begin
                        phase_next = (answers_left_reg == 16'd0) ? PH_DONE : PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (b[7:6] == POINTER_TAG)
                    begin
                        phase_next = PH_POINTER;
                    end
                    else if (b == 8'd0)
                    begin
                        phase_next = PH_FIXED;
                        sec_next   = '0;
                    end
                    else
                    begin
                        label_next = b;
                        phase_next = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    label_next = label_reg - 8'd1;
                    if (label_next == 8'd0)
                    begin
                        phase_next = PH_NAME;
                    end
                end
                PH_POINTER:
                begin
                    phase_next = PH_FIXED;
                    sec_next   = '0;
                end
                PH_FIXED:
                begin
                    if (sec_reg < FIX_TYPE_END)
                    begin
                        rtype_next = {rtype_reg[7:0], b};
                    end
                    else if (sec_reg >= FIX_RDLEN_FIRST)
                    begin
                        rdata_left_next = {rdata_left_reg[7:0], b};
                    end
                    if (sec_reg >= FIX_LAST_BYTE)
                    begin
                        sec_next     = '0;
                        addr_lo_next = '0;
                        addr_hi_next = '0;
                        abc_next     = '0;
                        if (rdata_left_next == 16'd0)
                        begin
                            rtype_next        = '0;
                            answers_left_next = answers_left_reg - 16'd1;
                            phase_next = (answers_left_next == 16'd0) ? PH_DONE : PH_NAME;
                        end
                        else
                        begin
                            phase_next = PH_RDATA;
                        end
                    end
                    else
                    begin
                        sec_next = sec_reg + SEC_W'(1);
                    end
                end
                PH_RDATA:
                begin
                    if (rtype_reg == RR_TYPE_A)
                    begin
                        addr_lo_next = {32'd0, addr_lo_reg[23:0], b};
                        abc_next     = abc_reg + ABC_W'(1);
                        if (abc_next >= IPV4_BYTES)
                        begin
                            addr_hit     = 1'b1;
                            res_lo       = addr_lo_next;
                            addr_lo_next = '0;
                            abc_next     = '0;
                        end
                    end
                    else if (rtype_reg == RR_TYPE_AAAA)
                    begin
                        if (abc_reg < IPV6_HIGH_BYTES)
                        begin
                            addr_hi_next = {addr_hi_reg[55:0], b};
                        end
                        else
                        begin
                            addr_lo_next = {addr_lo_reg[55:0], b};
                        end
                        abc_next = abc_reg + ABC_W'(1);
                        if (abc_next >= IPV6_BYTES)
                        begin
                            addr_hit     = 1'b1;
                            addr_family  = FAMILY_IPV6;
                            res_hi       = addr_hi_next;
                            res_lo       = addr_lo_next;
                            addr_lo_next = '0;
                            addr_hi_next = '0;
                            abc_next     = '0;
                        end
                    end
                    rdata_left_next = rdata_left_reg - 16'd1;
                    if (rdata_left_next == 16'd0)
                    begin
                        rtype_next        = '0;
                        addr_lo_next      = '0;
                        addr_hi_next      = '0;
                        abc_next          = '0;
                        answers_left_next = answers_left_reg - 16'd1;
                        phase_next = (answers_left_next == 16'd0) ? PH_DONE : PH_NAME;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (err_next != ST_OK)
        begin
            st = err_next;
        end
        else if (phase_next == PH_DONE)
        begin
            st = ST_OK;
        end
        else
        begin
            st = ST_TRUNCATED;
        end

        addr_res.kind          = KIND_ADDRESS;
        addr_res.family        = addr_family;
        addr_res.addr_high     = res_hi;
        addr_res.addr_low      = res_lo;
        addr_res.status        = ST_OK;
        addr_res.response_code = rcode_next;
        addr_res.answer_total  = ancount_next;
        addr_res.final_res     = !eom;

        status_res.kind          = KIND_STATUS;
        status_res.family        = FAMILY_IPV4;
        status_res.addr_high     = '0;
        status_res.addr_low      = '0;
        status_res.status        = st;
        status_res.response_code = rcode_next;
        status_res.answer_total  = ancount_next;
        status_res.final_res     = 1'b1;

        push.first  = addr_hit ? addr_res : status_res;
        push.second = status_res;
        push.count  = item_valid ? ({1'b0, addr_hit} + {1'b0, eom}) : 2'd0;

        if (item_valid && eom)
        begin
            phase_next        = PH_HEADER;
            sec_next          = '0;
            answers_left_next = '0;
            ancount_next      = '0;
            rcode_next        = '0;
            err_next          = ST_OK;
            rtype_next        = '0;
            rdata_left_next   = '0;
            label_next        = '0;
            addr_lo_next      = '0;
            addr_hi_next      = '0;
            abc_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            sec_reg          <= '0;
            answers_left_reg <= '0;
            ancount_reg      <= '0;
            rcode_reg        <= '0;
            err_reg          <= ST_OK;
            rtype_reg        <= '0;
            rdata_left_reg   <= '0;
            label_reg        <= '0;
            addr_lo_reg      <= '0;
            addr_hi_reg      <= '0;
            abc_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            sec_reg          <= sec_next;
            answers_left_reg <= answers_left_next;
            ancount_reg      <= ancount_next;
            rcode_reg        <= rcode_next;
            err_reg          <= err_next;
            rtype_reg        <= rtype_next;
            rdata_left_reg   <= rdata_left_next;
            label_reg        <= label_next;
            addr_lo_reg      <= addr_lo_next;
            addr_hi_reg      <= addr_hi_next;
            abc_reg          <= abc_next;
        end
    end

    `DRAP_ASSERT_IMPLIES(a_pair_order, clk, rst_n, push.count == 2'd2, (push.first.kind == KIND_ADDRESS) && (push.second.kind == KIND_STATUS))
    `DRAP_ASSERT_IMPLIES(a_eom_reports, clk, rst_n, item_valid && item.end_of_message, push.count != 2'd0)
    `DRAP_ASSERT_NEXT(a_eom_restarts, clk, rst_n, item_valid && item.end_of_message, phase_reg == PH_HEADER)
    `DRAP_ASSERT_ALWAYS(a_error_coded, clk, rst_n, (phase_reg == PH_ERROR) == (err_reg != ST_OK))

endmodule

// ===== rtl/dns_response_address_parser.sv =====
// Top level of the DNS response address parser: input register, parser
// and result queue. Depends on drap_pkg, drap_parser and drap_result_fifo.
//
// The block takes one message byte per cycle while msg_ready is high and reports
// each complete A or AAAA address of the answer section, followed by a status
// result on the byte that ends the message. A byte is registered on transfer and
// parsed in the next cycle, which writes its results into the output queue; they
// leave from the queue's head. The eight-entry result queue sets the rate:
// msg_ready stays high while it holds four entries or fewer, so with a consumer
// that takes a result every cycle the block sustains one byte per cycle. A final
// byte that completes an address yields two results, handed out one per transfer.
// The question length register is sampled when the header ends and should be
// written between messages.
module dns_response_address_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    output logic                      msg_ready,
    input  drap_pkg::drap_item_t      msg_item,
    output logic                      res_valid,
    input  logic                      res_ready,
    output drap_pkg::drap_result_t    res_item,
    input  logic                      cfg_we,
    input  logic [drap_pkg::QLEN_W-1:0] cfg_wdata
);
    import drap_pkg::*;

    logic              msg_valid_reg;
    logic              msg_valid_next;
    drap_item_t        msg_item_reg;
    logic [QLEN_W-1:0] qlen_reg;
    logic [QLEN_W-1:0] qlen_next;
    logic              room;
    logic              pop;
    drap_push_t        push;

    assign msg_ready      = room;
    assign msg_valid_next = msg_valid && room;
    assign qlen_next      = cfg_we ? cfg_wdata : qlen_reg;
    assign pop            = res_valid && res_ready;

    always_ff @(posedge clk)
    begin
        if (msg_valid_next)
        begin
            msg_item_reg <= msg_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_reg <= 1'b0;
            qlen_reg      <= QLEN_RESET;
        end
        else
        begin
            msg_valid_reg <= msg_valid_next;
            qlen_reg      <= qlen_next;
        end
    end

    drap_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (msg_valid_reg),
        .item            (msg_item_reg),
        .question_length (qlen_reg),
        .push            (push)
    );

    drap_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (res_item),
        .not_empty (res_valid),
        .room      (room)
    );

endmodule

// ===== tb/sv/tb_dns_response_address_parser.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dns_response_address_parser: directed and random DNS responses.
// Expected addresses and statuses come from a behavioral parser kept inside this file.
// Depends on drap_pkg and the dns_response_address_parser RTL.
module tb_dns_response_address_parser;
    import drap_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BUDGET = 40;

    localparam logic [QLEN_W-1:0] QLEN_LOW = 9'd5;
    localparam logic [QLEN_W-1:0] QLEN_MAX = 9'd259;
    localparam logic [15:0] RR_TYPE_CNAME = 16'd5;

    localparam int NAME_POINTER = 0;
    localparam int NAME_ROOT = 1;
    localparam int NAME_LABELS = 2;
    localparam int NAME_LABELS_POINTER = 3;
    localparam int FILL_RANDOM = -1;
    localparam int NO_PAUSE = -1;

    logic clk = 1'b0;
    logic rst_n;
    logic msg_valid;
    logic msg_ready;
    drap_item_t msg_item;
    logic res_valid;
    logic res_ready = 1'b0;
    drap_result_t res_item;
    logic cfg_we;
    logic [QLEN_W-1:0] cfg_wdata;

    int unsigned cycle_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int failures = 0;
    int results_checked = 0;
    int addresses_seen = 0;
    int messages_sent = 0;
    int bytes_sent = 0;
    int qlen_writes = 0;
    int last_live;

    drap_result_t awaited_records[$];
    logic [7:0] msg_buf[$];
    int msg_ignored = 0;

    drap_phase_t ph;
    logic [15:0] sec_cnt;
    logic [15:0] ans_left;
    logic [15:0] ans_total;
    logic [15:0] rtype;
    logic [15:0] rd_left;
    logic [3:0] rcode;
    logic [2:0] err;
    logic [7:0] lbl_left;
    logic [63:0] acc_hi;
    logic [63:0] acc_lo;
    logic [4:0] acc_cnt;
    logic [QLEN_W-1:0] qlen_setting;

    dns_response_address_parser DUT (
        .clk(clk),
        .rst_n(rst_n),
        .msg_valid(msg_valid),
        .msg_ready(msg_ready),
        .msg_item(msg_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item(res_item),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    always @(negedge clk)
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
                     awaited_records.size());
            $display("tb_dns_response_address_parser failed");
            $finish;
        end
    end

    function automatic void clear_parse_state();
        ph = PH_HEADER;
        sec_cnt = '0;
        ans_left = '0;
        ans_total = '0;
        rtype = '0;
        rd_left = '0;
        rcode = '0;
        err = ST_OK;
        lbl_left = '0;
        acc_hi = '0;
        acc_lo = '0;
        acc_cnt = '0;
    endfunction

    function automatic void enter_answers();
        if (ans_left == 16'd0)
            ph = PH_DONE;
        else
            ph = PH_NAME;
    endfunction

    function automatic void next_answer();
        ans_left = ans_left - 16'd1;
        enter_answers();
    endfunction

    function automatic void start_fixed();
        ph = PH_FIXED;
        sec_cnt = '0;
    endfunction

    function automatic void stop_parse(input logic [2:0] code);
        err = code;
        ph = PH_ERROR;
    endfunction

    function automatic drap_result_t form_result(input logic kind, input logic fam,
                                                 input logic [63:0] hi, input logic [63:0] lo,
                                                 input logic [2:0] st);
        drap_result_t r;
        r.kind = kind;
        r.family = fam;
        r.addr_high = hi;
        r.addr_low = lo;
        r.status = st;
        r.response_code = rcode;
        r.answer_total = ans_total;
        r.final_res = 1'b0;
        return r;
    endfunction

    // Advances the parser by one message byte and queues the results it causes.
    task automatic parse_response_byte(input logic [7:0] b, input logic eom);
        drap_result_t made [MAX_RESULTS];
        int made_count;
        logic [2:0] st;
        made_count = 0;
        case (ph)
            PH_HEADER:
            begin
                if (sec_cnt == HDR_FLAGS_BYTE)
                    rcode = b[3:0];
                if (sec_cnt == HDR_QD_HI_BYTE)
                    rtype = {8'h00, b};
                if (sec_cnt == HDR_QD_LO_BYTE)
                    rtype = {rtype[7:0], b};
                if (sec_cnt == HDR_AN_HI_BYTE)
                    ans_total = {8'h00, b};
                if (sec_cnt == HDR_AN_LO_BYTE)
                begin
                    ans_total = {ans_total[7:0], b};
                    ans_left = ans_total;
                end
                if (sec_cnt == HDR_QR_BYTE && !b[QR_BIT])
                    stop_parse(ST_NOT_RESPONSE);
                else if (sec_cnt == HDR_FLAGS_BYTE && rcode != 4'h0)
                    stop_parse(ST_RCODE_ERROR);
                else if (sec_cnt == HDR_QD_LO_BYTE && rtype != QDCOUNT_ONE)
                    stop_parse(ST_QDCOUNT_BAD);
                else if (sec_cnt >= HDR_LAST_BYTE)
                begin
                    rtype = '0;
                    if (qlen_setting == '0)
                        enter_answers();
                    else
                    begin
                        ph = PH_QUESTION;
                        sec_cnt = 16'(qlen_setting);
                    end
                end
                else
                    sec_cnt = sec_cnt + 16'd1;
            end
            PH_QUESTION:
            begin
                sec_cnt = sec_cnt - 16'd1;
                if (sec_cnt == 16'd0)
                    enter_answers();
            end
            PH_NAME:
            begin
                if (b[7:6] == POINTER_TAG)
                    ph = PH_POINTER;
                else if (b == 8'h00)
                    start_fixed();
                else
                begin
                    lbl_left = b;
                    ph = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                lbl_left = lbl_left - 8'd1;
                if (lbl_left == 8'd0)
                    ph = PH_NAME;
            end
            PH_POINTER:
                start_fixed();
            PH_FIXED:
            begin
                if (sec_cnt < FIX_TYPE_END)
                    rtype = {rtype[7:0], b};
                else if (sec_cnt >= FIX_RDLEN_FIRST)
                    rd_left = {rd_left[7:0], b};
                if (sec_cnt >= FIX_LAST_BYTE)
                begin
                    sec_cnt = '0;
                    acc_hi = '0;
                    acc_lo = '0;
                    acc_cnt = '0;
                    if (rd_left == 16'd0)
                    begin
                        rtype = '0;
                        next_answer();
                    end
                    else
                        ph = PH_RDATA;
                end
                else
                    sec_cnt = sec_cnt + 16'd1;
            end
            PH_RDATA:
            begin
                if (rtype == RR_TYPE_A)
                begin
                    acc_lo = {32'h0, acc_lo[23:0], b};
                    acc_cnt = acc_cnt + 5'd1;
                    if (acc_cnt >= IPV4_BYTES)
                    begin
                        made[made_count] = form_result(KIND_ADDRESS, FAMILY_IPV4, 64'h0, acc_lo,
                                                       ST_OK);
                        made_count++;
                        acc_lo = '0;
                        acc_cnt = '0;
                    end
                end
                else if (rtype == RR_TYPE_AAAA)
                begin
                    if (acc_cnt < IPV6_HIGH_BYTES)
                        acc_hi = {acc_hi[55:0], b};
                    else
                        acc_lo = {acc_lo[55:0], b};
                    acc_cnt = acc_cnt + 5'd1;
                    if (acc_cnt >= IPV6_BYTES)
                    begin
                        made[made_count] = form_result(KIND_ADDRESS, FAMILY_IPV6, acc_hi, acc_lo,
                                                       ST_OK);
                        made_count++;
                        acc_hi = '0;
                        acc_lo = '0;
                        acc_cnt = '0;
                    end
                end
                rd_left = rd_left - 16'd1;
                if (rd_left == 16'd0)
                begin
                    rtype = '0;
                    acc_hi = '0;
                    acc_lo = '0;
                    acc_cnt = '0;
                    next_answer();
                end
            end
            default:
            begin
            end
        endcase
        if (eom)
        begin
            if (err != ST_OK)
                st = err;
            else if (ph == PH_DONE)
                st = ST_OK;
            else
                st = ST_TRUNCATED;
            made[made_count] = form_result(KIND_STATUS, FAMILY_IPV4, 64'h0, 64'h0, st);
            made_count++;
            clear_parse_state();
        end
        if (made_count > 0)
            made[made_count - 1].final_res = 1'b1;
        for (int i = 0; i < made_count; i++)
            awaited_records.push_back(made[i]);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : check_output
        drap_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_records.size() == 0)
            begin
                $display("%0t ns: result with none expected, expected nothing, actual %0h",
                         $time, res_item);
                failures++;
            end
            else
            begin
                want = awaited_records.pop_front();
                compare_field("kind", 64'(want.kind), 64'(res_item.kind));
                compare_field("family", 64'(want.family), 64'(res_item.family));
                compare_field("addr_high", want.addr_high, res_item.addr_high);
                compare_field("addr_low", want.addr_low, res_item.addr_low);
                compare_field("status", 64'(want.status), 64'(res_item.status));
                compare_field("response_code", 64'(want.response_code),
                              64'(res_item.response_code));
                compare_field("answer_total", 64'(want.answer_total),
                              64'(res_item.answer_total));
                compare_field("final_res", 64'(want.final_res), 64'(res_item.final_res));
                results_checked++;
                if (want.kind == KIND_ADDRESS)
                    addresses_seen++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eom);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_item <= '{data_byte: b, end_of_message: eom};
        msg_valid <= 1'b1;
        @(posedge clk);
        while (!msg_ready)
            @(posedge clk);
        parse_response_byte(b, eom);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (awaited_records.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_question_length(input logic [QLEN_W-1:0] value);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        qlen_setting = value;
        qlen_writes++;
    endtask

    // Sends the built message, cut short when send_len is positive and below its length; the last byte sent ends it.
    task automatic send_message(input int send_len, input int pause_at);
        int total;
        total = (send_len > 0 && send_len < msg_buf.size()) ? send_len : msg_buf.size();
        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
                wait_drain();
            send_byte(msg_buf[i], i == total - 1);
        end
        last_live = (total == msg_buf.size()) ? total - msg_ignored : total;
        bytes_sent += total;
        messages_sent++;
        msg_buf.delete();
        msg_ignored = 0;
    endtask

    task automatic add_random_bytes(input int count, input int fill);
        for (int i = 0; i < count; i++)
            msg_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    endtask

    task automatic add_ignored(input int count);
        msg_ignored += count;
        add_random_bytes(count, FILL_RANDOM);
    endtask

    task automatic add_header(input logic qr, input logic [3:0] rc, input logic [15:0] qd,
                              input logic [15:0] an);
        add_random_bytes(2, FILL_RANDOM);
        msg_buf.push_back({qr, 7'($urandom)});
        msg_buf.push_back({4'($urandom), rc});
        msg_buf.push_back(qd[15:8]);
        msg_buf.push_back(qd[7:0]);
        msg_buf.push_back(an[15:8]);
        msg_buf.push_back(an[7:0]);
        add_random_bytes(4, FILL_RANDOM);
    endtask

    task automatic add_question();
        add_random_bytes(int'(qlen_setting), FILL_RANDOM);
    endtask

    task automatic add_name(input int style, input int first_len);
        int labels;
        int len;
        if (style == NAME_POINTER)
        begin
            msg_buf.push_back({POINTER_TAG, 6'($urandom)});
            msg_buf.push_back(8'($urandom));
        end
        else if (style == NAME_ROOT)
            msg_buf.push_back(8'h00);
        else
        begin
            labels = $urandom_range(1, 3);
            for (int i = 0; i < labels; i++)
            begin
                len = (i == 0 && first_len != 0) ? first_len : $urandom_range(1, 12);
                msg_buf.push_back(8'(len));
                add_random_bytes(len, FILL_RANDOM);
            end
            if (style == NAME_LABELS_POINTER)
                add_name(NAME_POINTER, 0);
            else
                msg_buf.push_back(8'h00);
        end
    endtask

    task automatic add_answer(input int style, input int first_len, input logic [15:0] rr,
                              input int rd_len, input int fill);
        add_name(style, first_len);
        msg_buf.push_back(rr[15:8]);
        msg_buf.push_back(rr[7:0]);
        add_random_bytes(6, FILL_RANDOM);
        msg_buf.push_back(8'(rd_len >> 8));
        msg_buf.push_back(8'(rd_len));
        add_random_bytes(rd_len, fill);
    endtask

    task automatic add_random_answer();
        int style;
        int first_len;
        int pick;
        int rd_len;
        logic [15:0] rr;
        style = $urandom_range(NAME_POINTER, NAME_LABELS_POINTER);
        first_len = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 191) : 0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            rr = RR_TYPE_A;
        else if (pick < 75)
            rr = RR_TYPE_AAAA;
        else
            rr = 16'($urandom);
        pick = $urandom_range(0, 3);
        if (rr == RR_TYPE_A)
            rd_len = (pick == 0) ? 8 : (pick == 1) ? $urandom_range(0, 9) : 4;
        else if (rr == RR_TYPE_AAAA)
            rd_len = (pick == 0) ? 32 : (pick == 1) ? $urandom_range(0, 20) : 16;
        else
            rd_len = $urandom_range(0, 8);
        add_answer(style, first_len, rr, rd_len, FILL_RANDOM);
    endtask

    function automatic logic [QLEN_W-1:0] random_qlen();
        if ($urandom_range(0, 9) == 0)
            return QLEN_W'($urandom_range(25, QLEN_MAX));
        return QLEN_W'($urandom_range(QLEN_LOW, 24));
    endfunction

    task automatic test_header_checks();
        msg_buf.push_back(8'hFF);
        send_message(0, NO_PAUSE);
        add_header(1'b0, 4'hF, QDCOUNT_ONE, 16'h0002);
        add_ignored(3);
        send_message(0, NO_PAUSE);
        add_header(1'b1, 4'hF, QDCOUNT_ONE, 16'h0001);
        add_ignored(2);
        send_message(0, NO_PAUSE);
        add_header(1'b1, 4'h0, 16'h0000, 16'h0001);
        send_message(0, NO_PAUSE);
        add_header(1'b1, 4'h0, 16'hFFFF, 16'h0001);
        add_ignored(1);
        send_message(0, NO_PAUSE);
    endtask

    task automatic test_zero_answers();
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'h0000);
        add_question();
        send_message(0, NO_PAUSE);
        write_question_length(QLEN_MAX);
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'h0000);
        add_question();
        add_ignored(4);
        send_message(0, NO_PAUSE);
    endtask

    task automatic test_answer_section();
        write_question_length(QLEN_LOW);
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'd6);
        add_question();
        add_answer(NAME_POINTER, 0, RR_TYPE_A, 4, 8'h00);
        add_answer(NAME_ROOT, 0, RR_TYPE_AAAA, 16, 8'hFF);
        add_answer(NAME_LABELS, 8'h40, RR_TYPE_CNAME, 3, FILL_RANDOM);
        add_answer(NAME_LABELS_POINTER, 8'h80, RR_TYPE_A, 6, FILL_RANDOM);
        add_answer(NAME_LABELS, 3, RR_TYPE_AAAA, 20, FILL_RANDOM);
        add_answer(NAME_ROOT, 0, RR_TYPE_A, 0, FILL_RANDOM);
        add_ignored(3);
        send_message(0, NO_PAUSE);
    endtask

    task automatic test_last_byte_address();
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'd1);
        add_question();
        add_answer(NAME_POINTER, 0, RR_TYPE_A, 4, FILL_RANDOM);
        send_message(0, NO_PAUSE);
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'd2);
        add_question();
        add_answer(NAME_LABELS, 0, RR_TYPE_A, 8, FILL_RANDOM);
        add_answer(NAME_ROOT, 0, RR_TYPE_AAAA, 16, FILL_RANDOM);
        send_message(0, NO_PAUSE);
    endtask

    task automatic test_early_end();
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'hFFFF);
        add_question();
        add_answer(NAME_ROOT, 0, RR_TYPE_AAAA, 32, FILL_RANDOM);
        send_message(0, msg_buf.size() - 10);
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'd2);
        add_question();
        add_answer(NAME_POINTER, 0, RR_TYPE_AAAA, 32, FILL_RANDOM);
        add_answer(NAME_ROOT, 0, RR_TYPE_A, 4, FILL_RANDOM);
        send_message(msg_buf.size() - 2, NO_PAUSE);
        add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'd1);
        add_question();
        send_message(14, NO_PAUSE);
    endtask

    task automatic test_random_messages(input int send_pct, input int recv_pct, input int budget);
        int done_bytes;
        int pick;
        int cut;
        int answers;
        logic [15:0] qd;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_question_length(random_qlen());
        done_bytes = 0;
        while (done_bytes < budget)
        begin
            if ($urandom_range(0, 9) == 0)
                write_question_length(random_qlen());
            pick = $urandom_range(0, 99);
            cut = 0;
            if (pick < 12)
            begin
                qd = 16'($urandom);
                if (qd == QDCOUNT_ONE)
                    qd = 16'h0000;
                case ($urandom_range(0, 2))
                    0: add_header(1'b0, 4'($urandom), QDCOUNT_ONE, 16'($urandom));
                    1: add_header(1'b1, 4'($urandom_range(1, 15)), QDCOUNT_ONE, 16'($urandom));
                    default: add_header(1'b1, 4'h0, qd, 16'($urandom));
                endcase
                add_ignored($urandom_range(0, 6));
            end
            else if (pick < 22)
                add_random_bytes($urandom_range(1, 16), FILL_RANDOM);
            else
            begin
                answers = $urandom_range(0, 3);
                add_header(1'b1, 4'h0, QDCOUNT_ONE, 16'(answers));
                add_question();
                repeat (answers) add_random_answer();
                if (pick < 40)
                    cut = $urandom_range(1, msg_buf.size() - 1);
                else if (pick < 55)
                    add_ignored($urandom_range(1, 6));
            end
            send_message(cut, NO_PAUSE);
            done_bytes += last_live;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        msg_valid = 1'b0;
        msg_item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        clear_parse_state();
        qlen_setting = QLEN_RESET;
        send_idle_pct = 31;
        recv_idle_pct = 55;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_checks();
        test_zero_answers();
        test_answer_section();
        test_last_byte_address();
        test_early_end();
        test_random_messages(31, 55, RANDOM_BUDGET);
        test_random_messages(55, 31, RANDOM_BUDGET);
        test_random_messages(0, 0, RANDOM_BUDGET);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d messages (%0d bytes) over %0d question length settings.",
                 messages_sent, bytes_sent, qlen_writes + 1);
        $display("Checked %0d results including %0d addresses; %0d mismatches.",
                 results_checked, addresses_seen, failures);
        if (failures == 0)
            $display("tb_dns_response_address_parser passed");
        else
            $display("tb_dns_response_address_parser failed");
        $finish;
    end

endmodule

// ===== dns_response_address_parser.f =====
+incdir+rtl
rtl/drap_pkg.sv
rtl/drap_result_fifo.sv
rtl/drap_parser.sv
rtl/dns_response_address_parser.sv
tb/sv/tb_dns_response_address_parser.sv
